/* rtl/dc_motor_ramp_reversal_control_core_assert.svh */
// assertion macros used by the checker module dcmr_chk
`ifndef DC_MOTOR_RAMP_REVERSAL_CONTROL_CORE_ASSERT_SVH
`define DC_MOTOR_RAMP_REVERSAL_CONTROL_CORE_ASSERT_SVH

// checked only while out of reset
`define DCMR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DCMR_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dcmr_pkg.sv */
package dcmr_pkg;

    localparam int DUTY_W    = 8;
    localparam int PCT_IN_W  = 7;
    localparam int PCT_OUT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [DUTY_W-1:0] DUTY_MAX        = 8'd255;
    localparam logic [DUTY_W-1:0] RAMP_STEP_RST   = 8'd2;
    localparam logic [DUTY_W-1:0] NEAR_STOP_RST   = 8'd5;

    // pct*255/100 == (pct*167127) >> 16 for every 7-bit pct
    localparam logic [17:0] PCT2DUTY_MUL = 18'd167127;
    // duty*100/255 == (duty*6579400) >> 24 for every 8-bit duty
    localparam logic [22:0] DUTY2PCT_MUL = 23'd6579400;

    typedef enum logic [1:0] {
        CMD_SET_SPEED = 2'd0,
        CMD_SET_DIR   = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_STOP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP = 1'b0,
        CFG_NEAR_STOP = 1'b1
    } t_cfg_idx;

    // what a result carries; the rest of the fields derive from it
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_dir              dir;
    } t_res;

    function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_IN_W-1:0] pct);
        logic [24:0] prod;
        logic [8:0]  raw;
        prod = 25'(pct) * 25'(PCT2DUTY_MUL);
        raw  = prod[24:16];
        return raw[8] ? DUTY_MAX : raw[DUTY_W-1:0];
    endfunction

    function automatic logic [PCT_OUT_W-1:0] duty_to_pct(input logic [DUTY_W-1:0] duty);
        logic [30:0] prod;
        prod = 31'(duty) * 31'(DUTY2PCT_MUL);
        return prod[30:24];
    endfunction

endpackage

/* rtl/dcmr_cmd_if.sv */
interface dcmr_cmd_if;
    import dcmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [PCT_IN_W-1:0] speed_percent;
    logic                immediate_flag;
    logic [1:0]          direction;

    modport source (output valid, output command, output speed_percent,
                    output immediate_flag, output direction, input ready);
    modport sink   (input valid, input command, input speed_percent,
                    input immediate_flag, input direction, output ready);
endinterface

/* rtl/dcmr_cfg_if.sv */
interface dcmr_cfg_if;
    import dcmr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dcmr_res_if.sv */
interface dcmr_res_if;
    import dcmr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DUTY_W-1:0]    pwm_duty;
    logic                 bridge_in1;
    logic                 bridge_in2;
    logic                 running;
    logic [PCT_OUT_W-1:0] speed_percent_now;
    logic [1:0]           direction_now;

    modport source (output valid, output pwm_duty, output bridge_in1, output bridge_in2,
                    output running, output speed_percent_now, output direction_now,
                    input ready);
    modport sink   (input valid, input pwm_duty, input bridge_in1, input bridge_in2,
                    input running, input speed_percent_now, input direction_now,
                    output ready);
endinterface

/* rtl/dc_motor_ramp_reversal_control_core.sv */
// h-bridge dc motor controller with soft-start ramp and safe reversal
//
// channels
//   i_cmd : one command per transfer (set speed, set direction, tick, stop)
//   i_cfg : register writes, index 0 ramp step, index 1 near-stop threshold;
//           always ready, write only while no command is in flight
//   o_res : one result per command, showing duty and direction after it
//
// timing
//   a command transfer updates the motor state at that edge and registers its
//   result (in the skid entry if a result waits); one command per cycle is sustained
//   while o_res takes results, the update being a single compare/add/select stage
//   o_res is backed by a two-entry output stage (result register plus skid),
//   so i_cmd stays ready while one result waits; i_cmd.ready drops only
//   when both entries are full, and rises again the cycle after a transfer
//
// reset
//   synchronous, active low: duty, target and saved target 0, direction stop,
//   no reversal pending, ramp step 2, threshold 5, output stage empty
module dc_motor_ramp_reversal_control_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcmr_cmd_if.sink    i_cmd,
    dcmr_cfg_if.sink    i_cfg,
    dcmr_res_if.source  o_res
);
    import dcmr_pkg::*;

    // configuration
    logic [DUTY_W-1:0] r_ramp_step;
    logic [DUTY_W-1:0] r_near_stop;

    // motor state
    logic [DUTY_W-1:0] r_cur_duty,   n_cur_duty;
    logic [DUTY_W-1:0] r_tgt_duty,   n_tgt_duty;
    logic [DUTY_W-1:0] r_saved_duty, n_saved_duty;
    t_dir              r_applied_dir, n_applied_dir;
    t_dir              r_pend_dir,    n_pend_dir;
    logic              r_rev_pending, n_rev_pending;

    // output stage
    logic r_out_v;
    t_res r_out;
    logic r_skid_v;
    t_res r_skid;

    logic              cmd_xfer;
    logic              res_xfer;
    logic [DUTY_W-1:0] req_duty;
    t_dir              req_dir;
    logic [DUTY_W-1:0] diff;
    logic [DUTY_W-1:0] step;
    logic [DUTY_W-1:0] ramp_duty;
    t_res              new_res;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_skid_v;
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign res_xfer    = r_out_v && o_res.ready;

    // requested duty and direction; direction code 3 means stop
    assign req_duty = pct_to_duty(i_cmd.speed_percent);
    assign req_dir  = (i_cmd.direction > DIR_BACK) ? DIR_STOP : t_dir'(i_cmd.direction);

    // one ramp step toward the target, never overshooting
    assign diff      = (r_tgt_duty > r_cur_duty) ? (r_tgt_duty - r_cur_duty)
                                                 : (r_cur_duty - r_tgt_duty);
    assign step      = (diff < r_ramp_step) ? diff : r_ramp_step;
    assign ramp_duty = (r_tgt_duty > r_cur_duty) ? (r_cur_duty + step)
                                                 : (r_cur_duty - step);

    always_comb begin
        n_cur_duty    = r_cur_duty;
        n_tgt_duty    = r_tgt_duty;
        n_saved_duty  = r_saved_duty;
        n_applied_dir = r_applied_dir;
        n_pend_dir    = r_pend_dir;
        n_rev_pending = r_rev_pending;
        case (t_cmd'(i_cmd.command))
            CMD_SET_SPEED: begin
                if (i_cmd.immediate_flag) begin
                    n_tgt_duty = req_duty;
                    n_cur_duty = req_duty;
                end else if (r_rev_pending) begin
                    // keep winding down, remember the speed for after reversal
                    n_tgt_duty   = '0;
                    n_saved_duty = req_duty;
                end else begin
                    n_tgt_duty = req_duty;
                end
            end
            CMD_SET_DIR: begin
                if (req_dir != r_applied_dir) begin
                    if (r_cur_duty != '0) begin
                        // moving: wind down first, saved target ends up zero
                        n_rev_pending = 1'b1;
                        n_pend_dir    = req_dir;
                        n_saved_duty  = '0;
                        n_tgt_duty    = '0;
                    end else begin
                        n_applied_dir = req_dir;
                    end
                end
            end
            CMD_TICK: begin
                if (r_rev_pending && (ramp_duty <= r_near_stop)) begin
                    // slow enough: cut the duty and swap direction
                    n_cur_duty    = '0;
                    n_applied_dir = r_pend_dir;
                    n_rev_pending = 1'b0;
                    n_tgt_duty    = r_saved_duty;
                end else begin
                    n_cur_duty = ramp_duty;
                end
            end
            CMD_STOP: begin
                if (r_applied_dir != DIR_STOP) begin
                    if (r_cur_duty != '0) begin
                        // stop is left pending, the next tick applies it
                        n_rev_pending = 1'b1;
                        n_pend_dir    = DIR_STOP;
                        n_saved_duty  = '0;
                    end else begin
                        n_applied_dir = DIR_STOP;
                    end
                end
                n_tgt_duty = '0;
                n_cur_duty = '0;
            end
            default: begin
            end
        endcase
    end

    assign new_res.duty = n_cur_duty;
    assign new_res.dir  = n_applied_dir;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step <= RAMP_STEP_RST;
            r_near_stop <= NEAR_STOP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_RAMP_STEP: r_ramp_step <= i_cfg.data;
                CFG_NEAR_STOP: r_near_stop <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // motor state, updated on each command transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_duty    <= '0;
            r_tgt_duty    <= '0;
            r_saved_duty  <= '0;
            r_applied_dir <= DIR_STOP;
            r_pend_dir    <= DIR_STOP;
            r_rev_pending <= 1'b0;
        end else if (cmd_xfer) begin
            r_cur_duty    <= n_cur_duty;
            r_tgt_duty    <= n_tgt_duty;
            r_saved_duty  <= n_saved_duty;
            r_applied_dir <= n_applied_dir;
            r_pend_dir    <= n_pend_dir;
            r_rev_pending <= n_rev_pending;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (res_xfer) begin
            if (r_skid_v) begin
                // skid full means no command was taken this cycle
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= cmd_xfer;
            end
        end else if (cmd_xfer) begin
            if (!r_out_v) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_xfer) begin
            r_out <= r_skid_v ? r_skid : new_res;
        end else if (cmd_xfer && !r_out_v) begin
            r_out <= new_res;
        end
        if (cmd_xfer && r_out_v && !res_xfer) begin
            r_skid <= new_res;
        end
    end

    // result fields derive from the registered duty and direction
    assign o_res.valid             = r_out_v;
    assign o_res.pwm_duty          = r_out.duty;
    assign o_res.bridge_in1        = (r_out.dir == DIR_FWD);
    assign o_res.bridge_in2        = (r_out.dir == DIR_BACK);
    assign o_res.running           = (r_out.dir != DIR_STOP);
    assign o_res.speed_percent_now = duty_to_pct(r_out.duty);
    assign o_res.direction_now     = r_out.dir;

endmodule

/* rtl/dcmr_chk.sv */
`include "dc_motor_ramp_reversal_control_core_assert.svh"

module dcmr_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [dcmr_pkg::DUTY_W-1:0]   i_res_duty,
    input logic                          i_res_in1,
    input logic                          i_res_in2,
    input logic                          i_res_running,
    input logic [1:0]                    i_res_dir
);
    import dcmr_pkg::*;

    // output stage is empty after reset
    `DCMR_ASSERT_ANY(a_rst_empty, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // a stalled result holds
    `DCMR_ASSERT_RST(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_duty) && $stable(i_res_dir), "stalled result changed")

    // bridge pins agree with running and never both high
    `DCMR_ASSERT_RST(a_bridge, i_clk, i_rst_n, i_res_valid |-> (i_res_running == (i_res_in1 || i_res_in2)) && !(i_res_in1 && i_res_in2), "bridge pins inconsistent")

    // a command taken with the output empty shows up the next cycle
    `DCMR_ASSERT_RST(a_latency, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready && !i_res_valid |=> i_res_valid, "result missing one cycle after command")

    // nothing waiting means commands are accepted
    `DCMR_ASSERT_RST(a_ready, i_clk, i_rst_n, !i_res_valid |-> i_cmd_ready, "command not ready with empty output")

endmodule

bind dc_motor_ramp_reversal_control_core dcmr_chk u_dcmr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_duty    (o_res.pwm_duty),
    .i_res_in1     (o_res.bridge_in1),
    .i_res_in2     (o_res.bridge_in2),
    .i_res_running (o_res.running),
    .i_res_dir     (o_res.direction_now)
);
